>>> design/mkpc_pkg.sv
// ----------------------------------------------------------------------------
// mkpc_pkg
// Shared types and constants of the multi-key press classifier.
// ----------------------------------------------------------------------------
package mkpc_pkg;

	localparam int TIMER_W = 8;
	localparam int COUNT_W = 16;
	localparam int CFG_W   = 8;
	localparam int IDX_W   = 2;
	localparam int KIND_W  = 2;

	localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HOLD      = 2'd1;
	localparam logic [IDX_W-1:0] REG_LONG_HOLD = 2'd2;

	localparam logic [KIND_W-1:0] EV_DOWN = 2'd0;
	localparam logic [KIND_W-1:0] EV_HOLD = 2'd1;
	localparam logic [KIND_W-1:0] EV_LONG = 2'd2;
	localparam logic [KIND_W-1:0] EV_UP   = 2'd3;

	localparam logic [TIMER_W-1:0] TIMER_MAX = 8'hFF;

	typedef struct packed {
		logic [TIMER_W-1:0] debounce;
		logic [TIMER_W-1:0] hold;
		logic [TIMER_W-1:0] long_hold;
	} thresh_t;

	typedef struct packed {
		logic               valid;
		logic [KIND_W-1:0]  kind;
		logic [COUNT_W-1:0] total;
		logic               last;
	} slot_t;

endpackage

>>> design/mkpc_key_cell.sv
// ----------------------------------------------------------------------------
// mkpc_key_cell
// One key: held timer, press counter and one event slot that shifts toward
// the output end of the row.
// ----------------------------------------------------------------------------
module mkpc_key_cell #(
	parameter int KW  = 2,
	parameter int KEY = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic                    shift,
	input  logic                    level,
	input  mkpc_pkg::thresh_t       thresh,
	input  mkpc_pkg::slot_t         nxt_slot,
	input  logic [KW-1:0]           nxt_key,
	input  logic                    later_in,
	output mkpc_pkg::slot_t         slot,
	output logic [KW-1:0]           key,
	output logic                    any_out
);
	import mkpc_pkg::*;

	logic [TIMER_W-1:0] timer_q;
	logic [COUNT_W-1:0] count_q;
	logic               valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [COUNT_W-1:0] total_q;
	logic               last_q;
	logic [KW-1:0]      key_q;

	logic               moved;
	logic [TIMER_W-1:0] timer_nxt;
	logic               down;
	logic               ev_valid;
	logic [KIND_W-1:0]  ev_kind;
	logic [COUNT_W-1:0] count_nxt;

	always_comb begin
		moved     = level && (timer_q != TIMER_MAX);
		timer_nxt = level ? (timer_q + TIMER_W'(moved)) : '0;
		down      = moved && ({1'b0, timer_nxt} == ({1'b0, thresh.debounce} + 9'd1));
		count_nxt = count_q + COUNT_W'(down);
		ev_valid  = 1'b0;
		ev_kind   = EV_DOWN;
		if (level) begin
			if (down) begin
				ev_valid = 1'b1;
				ev_kind  = EV_DOWN;
			end else if (timer_nxt > thresh.long_hold) begin
				ev_valid = 1'b1;
				ev_kind  = EV_LONG;
			end else if (timer_nxt > thresh.hold) begin
				ev_valid = 1'b1;
				ev_kind  = EV_HOLD;
			end
		end else if (timer_q > thresh.debounce) begin
			ev_valid = 1'b1;
			ev_kind  = EV_UP;
		end
	end

	assign any_out = ev_valid || later_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			count_q <= '0;
		end else if (load) begin
			timer_q <= timer_nxt;
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= ev_valid;
		end else if (shift) begin
			valid_q <= nxt_slot.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= ev_kind;
			total_q <= count_nxt;
			last_q  <= ev_valid && !later_in;
			key_q   <= KW'(KEY);
		end else if (shift) begin
			kind_q  <= nxt_slot.kind;
			total_q <= nxt_slot.total;
			last_q  <= nxt_slot.last;
			key_q   <= nxt_key;
		end
	end

	assign slot = {valid_q, kind_q, total_q, last_q};
	assign key  = key_q;

endmodule

>>> design/multi_key_press_classifier.sv
// ----------------------------------------------------------------------------
// multi_key_press_classifier
// Key debounce with hold and long press reporting over a row of key cells.
// ----------------------------------------------------------------------------
// Each accepted transaction is one scan tick. All key cells update their
// timers and press counters at once and park their event, if any, in a slot;
// the slot row then shifts one place per cycle toward the output register
// while the output is not stalled, and the next tick is taken in the cycle
// the last slot leaves. Events come out in key order, the final one of a
// tick marked by last_event; a stalled output holds the row.
module multi_key_press_classifier #(
	parameter  int NUM_KEYS = 4,
	localparam int KW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mkpc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [mkpc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [NUM_KEYS-1:0]           key_levels,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [KW-1:0]                 key_index,
	output logic [mkpc_pkg::KIND_W-1:0]   event_kind,
	output logic [mkpc_pkg::COUNT_W-1:0]  press_total,
	output logic                          last_event
);
	import mkpc_pkg::*;

	localparam int CW = $clog2(NUM_KEYS + 1);

	thresh_t                     thresh_q;
	logic [CW-1:0]               cnt_q;
	logic                        out_valid_q;
	logic [KW-1:0]               key_q;
	logic [KIND_W-1:0]           kind_q;
	logic [COUNT_W-1:0]          total_q;
	logic                        last_q;

	slot_t                       slots   [NUM_KEYS];
	logic [NUM_KEYS-1:0][KW-1:0] keys;
	logic [NUM_KEYS-1:0]         any;

	logic advance;
	logic shift;
	logic load;

	assign advance  = !out_valid_q || out_ready;
	assign shift    = advance && (cnt_q != '0);
	assign in_ready = (cnt_q == '0) || ((cnt_q == CW'(1)) && advance);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.debounce  <= 8'd1;
			thresh_q.hold      <= 8'd50;
			thresh_q.long_hold <= 8'd150;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:  thresh_q.debounce  <= cfg_data;
				REG_HOLD:      thresh_q.hold      <= cfg_data;
				REG_LONG_HOLD: thresh_q.long_hold <= cfg_data;
				default: ;
			endcase
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < NUM_KEYS; gi++) begin : g_cell
			slot_t         nxt_slot;
			logic [KW-1:0] nxt_key;
			logic          later;
			if (gi == NUM_KEYS - 1) begin : g_end
				assign nxt_slot = '0;
				assign nxt_key  = '0;
				assign later    = 1'b0;
			end else begin : g_mid
				assign nxt_slot = slots[gi+1];
				assign nxt_key  = keys[gi+1];
				assign later    = any[gi+1];
			end
			mkpc_key_cell #(
				.KW (KW),
				.KEY(gi)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.load    (load),
				.shift   (shift),
				.level   (key_levels[gi]),
				.thresh  (thresh_q),
				.nxt_slot(nxt_slot),
				.nxt_key (nxt_key),
				.later_in(later),
				.slot    (slots[gi]),
				.key     (keys[gi]),
				.any_out (any[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= CW'(NUM_KEYS);
			end else if (shift) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (advance) begin
				out_valid_q <= shift && slots[0].valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_q   <= keys[0];
			kind_q  <= slots[0].kind;
			total_q <= slots[0].total;
			last_q  <= slots[0].last;
		end
	end

	assign out_valid   = out_valid_q;
	assign key_index   = key_q;
	assign event_kind  = kind_q;
	assign press_total = total_q;
	assign last_event  = last_q;

endmodule

>>> tb/tb_multi_key_press_classifier.sv
// ----------------------------------------------------------------------------
// tb_multi_key_press_classifier
// Self-checking bench for the multi-key press classifier. Scan ticks go in
// through the valid/ready input channel. A behavioral copy of the key timers
// and press counters predicts the event stream of each tick, and every output
// transaction is compared in order against it, field by field.
// ----------------------------------------------------------------------------
module tb_multi_key_press_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	import mkpc_pkg::*;

	localparam int NUM_KEYS      = 4;
	localparam int SETTLE_CYCLES = 4 * NUM_KEYS + 4;
	localparam int CYCLE_LIMIT   = 200000;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         key;
		logic [KIND_W-1:0]  kind;
		logic [COUNT_W-1:0] total;
		logic               last;
	} key_event_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_we     = 1'b0;
	logic [IDX_W-1:0]    cfg_index  = '0;
	logic [CFG_W-1:0]    cfg_data   = '0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [NUM_KEYS-1:0] key_levels = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [1:0]          key_index;
	logic [KIND_W-1:0]   event_kind;
	logic [COUNT_W-1:0]  press_total;
	logic                last_event;

	thresh_t            thr;
	logic [TIMER_W-1:0] key_timer [NUM_KEYS];
	logic [COUNT_W-1:0] key_presses [NUM_KEYS];
	key_event_t         pending_events [$];
	int                 mismatch_count = 0;
	int                 cycle_count    = 0;
	bit                 no_idle        = 1'b0;

	multi_key_press_classifier #(.NUM_KEYS(NUM_KEYS)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key_levels  (key_levels),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_index   (key_index),
		.event_kind  (event_kind),
		.press_total (press_total),
		.last_event  (last_event)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("multi_key_press_classifier verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= 17);
	end

	task automatic report_mismatch(input string field, input logic [COUNT_W-1:0] got,
			input logic [COUNT_W-1:0] want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		mismatch_count++;
	endtask

	function automatic key_event_t make_event(input int k, input logic [KIND_W-1:0] kind);
		key_event_t ev;
		ev.key   = k[1:0];
		ev.kind  = kind;
		ev.total = key_presses[k];
		ev.last  = 1'b0;
		return ev;
	endfunction

	// advance every key timer for one scan tick and queue its events
	function automatic void classify_tick(input logic [NUM_KEYS-1:0] lv);
		key_event_t evs [NUM_KEYS];
		int         n;
		logic [8:0] down_mark;
		logic       moved;
		n = 0;
		down_mark = {1'b0, thr.debounce} + 9'd1;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (lv[k]) begin
				moved = key_timer[k] != TIMER_MAX;
				if (moved)
					key_timer[k] = key_timer[k] + 8'd1;
				if (moved && {1'b0, key_timer[k]} == down_mark) begin
					key_presses[k] = key_presses[k] + 16'd1;
					evs[n] = make_event(k, EV_DOWN);
					n++;
				end else if (key_timer[k] > thr.long_hold) begin
					evs[n] = make_event(k, EV_LONG);
					n++;
				end else if (key_timer[k] > thr.hold) begin
					evs[n] = make_event(k, EV_HOLD);
					n++;
				end
			end else begin
				if (key_timer[k] > thr.debounce) begin
					evs[n] = make_event(k, EV_UP);
					n++;
				end
				key_timer[k] = '0;
			end
		end
		if (n > 0)
			evs[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_events.push_back(evs[i]);
	endfunction

	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("transaction with nothing expected, key_index",
					COUNT_W'(key_index), '0);
			end else begin
				want = pending_events.pop_front();
				if (key_index !== want.key)
					report_mismatch("key_index", COUNT_W'(key_index), COUNT_W'(want.key));
				if (event_kind !== want.kind)
					report_mismatch("event_kind", COUNT_W'(event_kind), COUNT_W'(want.kind));
				if (press_total !== want.total)
					report_mismatch("press_total", press_total, want.total);
				if (last_event !== want.last)
					report_mismatch("last_event", COUNT_W'(last_event), COUNT_W'(want.last));
			end
		end
	end

	task automatic send_tick(input logic [NUM_KEYS-1:0] lv);
		while (!no_idle && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		key_levels <= lv;
		do @(posedge clk); while (!in_ready);
		classify_tick(lv);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);
	endtask

	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_DEBOUNCE:  thr.debounce = data;
			REG_HOLD:      thr.hold = data;
			REG_LONG_HOLD: thr.long_hold = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hld,
			input logic [CFG_W-1:0] lng);
		wait_idle();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_HOLD, hld);
		write_reg(REG_LONG_HOLD, lng);
	endtask

	task automatic test_reset_defaults();
		send_tick(4'b0000);
		send_tick(4'b1111);
		send_tick(4'b1111);
		send_tick(4'b0000);
		send_tick(4'b0101);
		send_tick(4'b0101);
		send_tick(4'b1010);
	endtask

	task automatic test_zero_thresholds();
		set_thresholds(8'd0, 8'd0, 8'd0);
		send_tick(4'b1111);
		send_tick(4'b1111);
		send_tick(4'b0000);
	endtask

	task automatic test_hold_then_long();
		set_thresholds(8'd0, 8'd1, 8'd3);
		repeat (5) send_tick(4'b0001);
		send_tick(4'b0000);
	endtask

	// long hold already passed while debouncing; down still wins on its tick
	task automatic test_down_precedence();
		set_thresholds(8'd3, 8'd0, 8'd0);
		repeat (4) send_tick(4'b0100);
		send_tick(4'b0000);
	endtask

	// debounce of 255 never yields down or up; unused index must not touch it
	task automatic test_debounce_ceiling();
		set_thresholds(8'd255, 8'd255, 8'd255);
		write_reg(REG_UNUSED, 8'd0);
		repeat (3) send_tick(4'b0010);
		send_tick(4'b0000);
	endtask

	task automatic test_timer_saturation();
		logic [NUM_KEYS-1:0] lv;
		set_thresholds(8'd254, 8'd100, 8'd200);
		for (int i = 0; i < 262; i++) begin
			lv = NUM_KEYS'($urandom());
			lv[3] = 1'b1;
			send_tick(lv);
		end
		send_tick(4'b0000);
	endtask

	task automatic test_random_sequences(input int ticks, input logic [CFG_W-1:0] deb,
			input logic [CFG_W-1:0] hld, input logic [CFG_W-1:0] lng,
			input bit steady, input bit pause_midway);
		int                  run_left [NUM_KEYS];
		logic [NUM_KEYS-1:0] level;
		logic [NUM_KEYS-1:0] lv;
		int                  max_run;
		set_thresholds(deb, hld, lng);
		no_idle <= steady;
		level = '0;
		foreach (run_left[k])
			run_left[k] = 0;
		max_run = int'(lng) + 8;
		if (max_run > 40)
			max_run = 40;
		for (int i = 0; i < ticks; i++) begin
			if (pause_midway && i == ticks / 2)
				wait_drained();
			if ($urandom_range(99) < 15) begin
				lv = NUM_KEYS'($urandom());
			end else begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					if (run_left[k] == 0) begin
						level[k] = ~level[k];
						run_left[k] = $urandom_range(max_run, 1);
					end
					run_left[k]--;
				end
				lv = level;
			end
			send_tick(lv);
		end
		no_idle <= 1'b0;
	endtask

	initial begin
		thr.debounce = 8'd1;
		thr.hold = 8'd50;
		thr.long_hold = 8'd150;
		foreach (key_timer[k]) begin
			key_timer[k] = '0;
			key_presses[k] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_thresholds();
		test_hold_then_long();
		test_down_precedence();
		test_debounce_ceiling();
		test_timer_saturation();
		test_random_sequences(50, CFG_W'($urandom_range(5)), CFG_W'($urandom_range(15)),
			CFG_W'($urandom_range(25)), 1'b0, 1'b1);
		test_random_sequences(50, 8'd2, 8'd6, 8'd12, 1'b1, 1'b0);
		test_random_sequences(50, 8'd0, 8'd255, 8'd255, 1'b0, 1'b0);
		test_random_sequences(50, CFG_W'($urandom_range(5)), CFG_W'($urandom_range(15)),
			CFG_W'($urandom_range(25)), 1'b0, 1'b1);

		wait_idle();
		if (mismatch_count == 0)
			$display("multi_key_press_classifier verification clean");
		else
			$display("multi_key_press_classifier verification failed");
		$finish;
	end

endmodule

>>> multi_key_press_classifier.f
design/mkpc_pkg.sv
design/mkpc_key_cell.sv
design/multi_key_press_classifier.sv
tb/tb_multi_key_press_classifier.sv
